### design/vfcce_pkg.sv
// Shared types, constants and cube geometry tables for the voxel cube emitter.
// Used by vfcce_sat_addsub and voxel_face_culled_cube_emitter; depends on nothing.
package vfcce_pkg;

  localparam int CoordW       = 24;
  localparam int SizeW        = 16;
  localparam int HalfW        = SizeW - 1;
  localparam int MaskW        = 6;
  localparam int FaceW        = 3;
  localparam int VertW        = 3;
  localparam int CornerW      = 3;
  localparam int CountW       = 32;
  localparam int NumFaces     = 6;
  localparam int VertsPerFace = 6;
  localparam int NumAxes      = 3;
  localparam int AxisW        = 2;
  localparam int StepW        = 3;
  localparam int InDataW      = 96;
  localparam int OutDataW     = 112;

  localparam logic signed [CoordW-1:0] CoordMax = {1'b0, {(CoordW-1){1'b1}}};
  localparam logic signed [CoordW-1:0] CoordMin = {1'b1, {(CoordW-1){1'b0}}};

  typedef logic signed [CoordW-1:0] coord_t;

  typedef enum logic [2:0] {
    StIdle = 3'b001,
    StCalc = 3'b010,
    StEmit = 3'b100
  } state_e;

  // Face codes in emission order.
  localparam logic [FaceW-1:0] FaceFront  = 3'd0;
  localparam logic [FaceW-1:0] FaceBack   = 3'd1;
  localparam logic [FaceW-1:0] FaceRight  = 3'd2;
  localparam logic [FaceW-1:0] FaceLeft   = 3'd3;
  localparam logic [FaceW-1:0] FaceTop    = 3'd4;
  localparam logic [FaceW-1:0] FaceBottom = 3'd5;

  // Sign bits of a corner: bit0 +x, bit1 +y, bit2 +z.
  function automatic logic [NumAxes-1:0] corner_sign(input logic [CornerW-1:0] c);
    logic [NumAxes-1:0] s;
    case (c)
      3'd0:    s = 3'd4;
      3'd1:    s = 3'd5;
      3'd2:    s = 3'd7;
      3'd3:    s = 3'd6;
      3'd4:    s = 3'd1;
      3'd5:    s = 3'd0;
      3'd6:    s = 3'd2;
      default: s = 3'd3;
    endcase
    return s;
  endfunction

  // Neighbor mask bit that suppresses each face.
  function automatic logic [2:0] face_bit(input logic [FaceW-1:0] f);
    logic [2:0] b;
    case (f)
      FaceFront:  b = 3'd1;
      FaceBack:   b = 3'd0;
      FaceRight:  b = 3'd5;
      FaceLeft:   b = 3'd4;
      FaceTop:    b = 3'd3;
      default:    b = 3'd2;
    endcase
    return b;
  endfunction

  // Corner order of the two triangles of each face, first vertex in the low bits.
  function automatic logic [CornerW-1:0] face_corner(input logic [FaceW-1:0] f,
                                                      input logic [VertW-1:0] k);
    logic [VertsPerFace-1:0][CornerW-1:0] row;
    logic [CornerW-1:0]                   c;
    case (f)
      FaceFront:  row = {3'd3, 3'd2, 3'd0, 3'd2, 3'd1, 3'd0};
      FaceBack:   row = {3'd7, 3'd6, 3'd4, 3'd6, 3'd5, 3'd4};
      FaceRight:  row = {3'd2, 3'd7, 3'd1, 3'd7, 3'd4, 3'd1};
      FaceLeft:   row = {3'd6, 3'd3, 3'd5, 3'd3, 3'd0, 3'd5};
      FaceTop:    row = {3'd6, 3'd7, 3'd3, 3'd7, 3'd2, 3'd3};
      default:    row = {3'd0, 3'd1, 3'd5, 3'd1, 3'd4, 3'd5};
    endcase
    case (k)
      3'd0:    c = row[0];
      3'd1:    c = row[1];
      3'd2:    c = row[2];
      3'd3:    c = row[3];
      3'd4:    c = row[4];
      default: c = row[5];
    endcase
    return c;
  endfunction

endpackage

### design/vfcce_sat_addsub.sv
// Shared saturating adder/subtractor: center coordinate plus or minus half edge.
// Depends on vfcce_pkg.
module vfcce_sat_addsub (
  input  vfcce_pkg::coord_t               center_i,
  input  logic [vfcce_pkg::HalfW-1:0]     half_i,
  input  logic                            sub_i,
  output vfcce_pkg::coord_t               result_o
);

  logic signed [vfcce_pkg::CoordW:0] ext_a;
  logic signed [vfcce_pkg::CoordW:0] ext_b;
  logic signed [vfcce_pkg::CoordW:0] sum;

  assign ext_a = {center_i[vfcce_pkg::CoordW-1], center_i};
  assign ext_b = $signed({{(vfcce_pkg::CoordW+1-vfcce_pkg::HalfW){1'b0}}, half_i});
  assign sum   = sub_i ? (ext_a - ext_b) : (ext_a + ext_b);

  // The two top bits differ exactly when the exact result leaves the 24-bit range.
  always_comb begin
    if (sum[vfcce_pkg::CoordW] != sum[vfcce_pkg::CoordW-1]) begin
      result_o = sum[vfcce_pkg::CoordW] ? vfcce_pkg::CoordMin : vfcce_pkg::CoordMax;
    end else begin
      result_o = sum[vfcce_pkg::CoordW-1:0];
    end
  end

endmodule

### design/voxel_face_culled_cube_emitter.sv
// Voxel cube emitter: one cube in, up to 36 vertices out, faces with a neighbor culled.
// After an input transfer the shared add/sub unit forms the six corner coordinates; then the
// sequencer passes over hidden faces and loads each visible vertex into the output register,
// held while it is full and not taken. No new cube is accepted until the sequencer is idle.
// Reset (rst_ni low, asynchronous) clears the sequencer, the output valid and the count.
// Depends on vfcce_pkg and vfcce_sat_addsub.
module voxel_face_culled_cube_emitter (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // Slave side. tdata from the lowest bit: center_x[23:0], center_y[47:24],
  // center_z[71:48], edge_size[87:72], neighbor_mask[93:88], zero fill.
  input  logic                              s_axis_tvalid_i,
  output logic                              s_axis_tready_o,
  input  logic [vfcce_pkg::InDataW-1:0]     s_axis_tdata_i,
  // Master side. tdata from the lowest bit: vertex_x[23:0], vertex_y[47:24],
  // vertex_z[71:48], face_id[74:72], cube_total[106:75], zero fill.
  // tlast carries last_vertex.
  output logic                              m_axis_tvalid_o,
  input  logic                              m_axis_tready_i,
  output logic [vfcce_pkg::OutDataW-1:0]    m_axis_tdata_o,
  output logic                              m_axis_tlast_o
);

  // Sequencer state and item registers.
  vfcce_pkg::state_e                     state_q, state_d;
  logic [vfcce_pkg::StepW-1:0]           step_q, step_d;
  logic [vfcce_pkg::FaceW-1:0]           face_q, face_d;
  logic [vfcce_pkg::VertW-1:0]           vert_q, vert_d;
  logic [vfcce_pkg::CountW-1:0]          count_q;

  vfcce_pkg::coord_t                     center_q [vfcce_pkg::NumAxes];
  vfcce_pkg::coord_t                     plus_q   [vfcce_pkg::NumAxes];
  vfcce_pkg::coord_t                     minus_q  [vfcce_pkg::NumAxes];
  logic [vfcce_pkg::HalfW-1:0]           half_q;
  logic [vfcce_pkg::MaskW-1:0]           mask_q;

  // Output register.
  logic                                  out_valid_q;
  vfcce_pkg::coord_t                     out_x_q, out_y_q, out_z_q;
  logic [vfcce_pkg::FaceW-1:0]           out_face_q;
  logic [vfcce_pkg::CountW-1:0]          out_total_q;
  logic                                  out_last_q;

  logic                                  in_xfer;
  logic                                  out_free;
  logic                                  load_out;
  logic [vfcce_pkg::AxisW-1:0]           calc_axis;
  vfcce_pkg::coord_t                     unit_result;
  logic [vfcce_pkg::NumFaces-1:0]        face_en;
  logic                                  later_en;
  logic                                  cur_en;
  logic                                  last_vert;
  logic [vfcce_pkg::CornerW-1:0]         corner;
  logic [vfcce_pkg::NumAxes-1:0]         sign;

  assign s_axis_tready_o = (state_q == vfcce_pkg::StIdle);
  assign in_xfer         = s_axis_tvalid_i && s_axis_tready_o;
  assign out_free        = !out_valid_q || m_axis_tready_i;

  // One shared unit forms all six corner coordinates: step bits [2:1] pick the
  // axis, bit 0 picks minus. The eight corners are selections of those six values.
  assign calc_axis = step_q[vfcce_pkg::StepW-1:1];

  vfcce_sat_addsub u_addsub (
    .center_i (center_q[calc_axis]),
    .half_i   (half_q),
    .sub_i    (step_q[0]),
    .result_o (unit_result)
  );

  // A face is visible when its neighbor bit is clear. The last vertex of a cube is
  // the sixth vertex of a visible face with no visible face after it.
  always_comb begin
    for (int f = 0; f < vfcce_pkg::NumFaces; f++) begin
      face_en[f] = !mask_q[vfcce_pkg::face_bit(vfcce_pkg::FaceW'(f))];
    end
    later_en = 1'b0;
    for (int f = 0; f < vfcce_pkg::NumFaces; f++) begin
      if (vfcce_pkg::FaceW'(f) > face_q) begin
        later_en = later_en | face_en[f];
      end
    end
  end

  assign cur_en    = face_en[face_q];
  assign last_vert = (vert_q == vfcce_pkg::VertW'(vfcce_pkg::VertsPerFace - 1)) && !later_en;
  assign load_out  = (state_q == vfcce_pkg::StEmit) && cur_en && out_free;
  assign corner    = vfcce_pkg::face_corner(face_q, vert_q);
  assign sign      = vfcce_pkg::corner_sign(corner);

  always_comb begin
    state_d = state_q;
    step_d  = step_q;
    face_d  = face_q;
    vert_d  = vert_q;
    case (state_q)
      vfcce_pkg::StIdle: begin
        if (in_xfer) begin
          state_d = vfcce_pkg::StCalc;
          step_d  = '0;
        end
      end
      vfcce_pkg::StCalc: begin
        step_d = step_q + 1'b1;
        if (step_q == vfcce_pkg::StepW'(2 * vfcce_pkg::NumAxes - 1)) begin
          state_d = vfcce_pkg::StEmit;
          face_d  = vfcce_pkg::FaceFront;
          vert_d  = '0;
        end
      end
      vfcce_pkg::StEmit: begin
        if (!cur_en) begin
          // Hidden face: pass over it without emitting a vertex.
          face_d = face_q + 1'b1;
          vert_d = '0;
          if (face_q == vfcce_pkg::FaceBottom) begin
            state_d = vfcce_pkg::StIdle;
          end
        end else if (out_free) begin
          if (last_vert) begin
            state_d = vfcce_pkg::StIdle;
          end else if (vert_q == vfcce_pkg::VertW'(vfcce_pkg::VertsPerFace - 1)) begin
            face_d = face_q + 1'b1;
            vert_d = '0;
          end else begin
            vert_d = vert_q + 1'b1;
          end
        end
      end
      default: begin
        state_d = vfcce_pkg::StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= vfcce_pkg::StIdle;
      step_q      <= '0;
      face_q      <= '0;
      vert_q      <= '0;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
      face_q  <= face_d;
      vert_q  <= vert_d;
      if (in_xfer) begin
        count_q <= count_q + 1'b1;
      end
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers carry no reset.
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      center_q[0] <= s_axis_tdata_i[23:0];
      center_q[1] <= s_axis_tdata_i[47:24];
      center_q[2] <= s_axis_tdata_i[71:48];
      // Half edge: the dropped fraction bit is truncated.
      half_q      <= s_axis_tdata_i[87:73];
      mask_q      <= s_axis_tdata_i[93:88];
    end
    if (state_q == vfcce_pkg::StCalc) begin
      if (step_q[0]) begin
        minus_q[calc_axis] <= unit_result;
      end else begin
        plus_q[calc_axis] <= unit_result;
      end
    end
    if (load_out) begin
      out_x_q     <= sign[0] ? plus_q[0] : minus_q[0];
      out_y_q     <= sign[1] ? plus_q[1] : minus_q[1];
      out_z_q     <= sign[2] ? plus_q[2] : minus_q[2];
      out_face_q  <= face_q;
      out_total_q <= count_q;
      out_last_q  <= last_vert;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tlast_o  = out_last_q;
  assign m_axis_tdata_o  = {5'b0, out_total_q, out_face_q, out_z_q, out_y_q, out_x_q};

endmodule
